// ===== hdl/hcfp_pkg.sv =====
`timescale 1ns / 1ps
// hcfp_pkg: shared types, constants and the hex decode function of the
// hex color frame parser. No dependencies.
package hcfp_pkg;

    localparam int unsigned CHAN_W        = 12;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned NIB_W         = 4;
    localparam int unsigned SHIFT_W       = 3 * CHAN_W;
    localparam int unsigned PHASE_W       = 4;
    localparam int unsigned APB_ADDR_W    = 3;
    localparam int unsigned APB_DATA_W    = 32;

    localparam logic [BYTE_W-1:0]  START_CHAR      = 8'h24;
    localparam logic [PHASE_W-1:0] PHASE_HUNT      = 4'd0;
    localparam logic [PHASE_W-1:0] PHASE_FIRST     = 4'd1;
    localparam logic [PHASE_W-1:0] PHASE_LAST      = 4'd9;

    localparam logic [CHAN_W-1:0]  RED_MARGIN_RST  = 12'd60;
    localparam logic [CHAN_W-1:0]  RED_FLOOR_RST   = 12'd50;

    // register index, taken from paddr word bit
    localparam logic REG_RED_MARGIN = 1'b0;
    localparam logic REG_RED_FLOOR  = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red_margin;
        logic [CHAN_W-1:0] red_floor;
    } hcfp_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              bad;
    } hcfp_frame_t;

    typedef struct packed {
        logic             is_hex;
        logic [NIB_W-1:0] nibble;
    } hcfp_digit_t;

    function automatic hcfp_digit_t hex_decode(input logic [BYTE_W-1:0] c);
        hcfp_digit_t d;
        d.is_hex = 1'b1;
        d.nibble = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.nibble = NIB_W'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.nibble = NIB_W'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.nibble = NIB_W'(c - 8'h37);
        end
        else
        begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/hcfp_cfg_regs.sv =====
`timescale 1ns / 1ps
// hcfp_cfg_regs: APB-style register file holding the red margin and floor.
// Depends on hcfp_pkg.
module hcfp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hcfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hcfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output hcfp_pkg::hcfp_cfg_t                 cfg
);
    import hcfp_pkg::*;

    logic [CHAN_W-1:0] margin_reg;
    logic [CHAN_W-1:0] floor_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    // registers sit on word boundaries, byte offset bits are ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= RED_MARGIN_RST;
            floor_reg  <= RED_FLOOR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_RED_MARGIN: margin_reg <= pwdata[CHAN_W-1:0];
                REG_RED_FLOOR:  floor_reg  <= pwdata[CHAN_W-1:0];
                default:        margin_reg <= margin_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_RED_MARGIN: prdata[CHAN_W-1:0] = margin_reg;
            REG_RED_FLOOR:  prdata[CHAN_W-1:0] = floor_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg.red_margin = margin_reg;
    assign cfg.red_floor  = floor_reg;

endmodule

// ===== hdl/hcfp_frame.sv =====
`timescale 1ns / 1ps
// hcfp_frame: input register, frame phase tracking and digit shift register.
// Depends on hcfp_pkg.
module hcfp_frame (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hcfp_pkg::BYTE_W-1:0]     rx_byte,
    output hcfp_pkg::hcfp_frame_t           done,
    input  logic                            done_ready
);
    import hcfp_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [BYTE_W-1:0]    byte_reg;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [SHIFT_W-1:0]   shift_next;
    logic                 bad_reg;
    logic                 bad_next;

    logic                 hunting;
    logic                 is_start;
    logic                 completes;
    logic                 fire;
    hcfp_digit_t          digit;
    logic [SHIFT_W-1:0]   shifted;

    assign hunting   = (phase_reg == PHASE_HUNT) || (phase_reg > PHASE_LAST);
    assign is_start  = (byte_reg == START_CHAR);
    assign digit     = hex_decode(byte_reg);
    assign shifted   = {shift_reg[SHIFT_W-NIB_W-1:0], digit.nibble};
    assign completes = !hunting && !is_start && (phase_reg == PHASE_LAST);

    // only a completing item has to wait for the result register
    assign fire      = in_valid_reg && (!completes || done_ready);
    assign in_ready  = !in_valid_reg || fire;

    assign done.valid = in_valid_reg && completes;
    assign done.red   = shifted[3*CHAN_W-1:2*CHAN_W];
    assign done.green = shifted[2*CHAN_W-1:CHAN_W];
    assign done.blue  = shifted[CHAN_W-1:0];
    assign done.bad   = bad_reg || !digit.is_hex;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        bad_next      = bad_reg;
        if (in_ready)
        begin
            in_valid_next = in_valid;
        end
        if (fire)
        begin
            priority if (hunting)
            begin
                if (is_start)
                begin
                    phase_next = PHASE_FIRST;
                    shift_next = '0;
                    bad_next   = 1'b0;
                end
                else
                begin
                    phase_next = PHASE_HUNT;
                end
            end
            else if (is_start)
            begin
                // start character inside a frame aborts it
                phase_next = PHASE_HUNT;
            end
            else
            begin
                shift_next = shifted;
                bad_next   = bad_reg || !digit.is_hex;
                phase_next = completes ? PHASE_HUNT : phase_reg + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PHASE_HUNT;
            shift_reg    <= '0;
            bad_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

// ===== hdl/hcfp_result.sv =====
`timescale 1ns / 1ps
// hcfp_result: red verdict compare and the output result register.
// Depends on hcfp_pkg.
module hcfp_result (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hcfp_pkg::hcfp_cfg_t             cfg,
    input  hcfp_pkg::hcfp_frame_t           done,
    output logic                            done_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hcfp_pkg::CHAN_W-1:0]     red_value,
    output logic [hcfp_pkg::CHAN_W-1:0]     green_value,
    output logic [hcfp_pkg::CHAN_W-1:0]     blue_value,
    output logic                            is_red,
    output logic                            bad_digit
);
    import hcfp_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    blue_reg;
    logic                 is_red_reg;
    logic                 bad_reg;

    logic [CHAN_W:0]      green_lim;
    logic [CHAN_W:0]      blue_lim;
    logic                 verdict;
    logic                 load;

    // sums kept one bit wider so the compare never wraps
    assign green_lim = {1'b0, done.green} + {1'b0, cfg.red_margin};
    assign blue_lim  = {1'b0, done.blue} + {1'b0, cfg.red_margin};
    assign verdict   = !done.bad
                       && ({1'b0, done.red} > green_lim)
                       && ({1'b0, done.red} > blue_lim)
                       && (done.red > cfg.red_floor);

    assign done_ready = !out_valid_reg || out_ready;
    assign load       = done.valid && done_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done_ready)
        begin
            out_valid_next = done.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg    <= done.red;
            green_reg  <= done.green;
            blue_reg   <= done.blue;
            is_red_reg <= verdict;
            bad_reg    <= done.bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_value   = red_reg;
    assign green_value = green_reg;
    assign blue_value  = blue_reg;
    assign is_red      = is_red_reg;
    assign bad_digit   = bad_reg;

endmodule

// ===== hdl/hex_color_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// hex_color_frame_parser_unit: top level of the hex color frame parser.
// Depends on hcfp_pkg, hcfp_cfg_regs, hcfp_frame, hcfp_result.
//
// usage
//   input channel in_valid / in_ready / rx_byte carries one received character
//   per item. bytes are ignored until a '$'; the next nine characters are hex
//   digits for red, green and blue (three each, msd first). a '$' inside a
//   frame drops it and the block hunts again.
//   output channel out_valid / out_ready carries one item per finished frame:
//   the three 12-bit channels, is_red and bad_digit.
//   red_margin (addr 0x0) and red_floor (addr 0x4) sit on the APB port.
// timing
//   one item per cycle unless a ninth digit waits for the output register;
//   an accepted byte lands in the input register, is decoded and shifted
//   into the shift register, a ninth digit's result into the output register.
//   a stalled receiver holds the output register; bytes keep flowing until a
//   ninth digit needs the occupied output register, then in_ready drops.
// reset
//   rst_n clears both valid flags and the frame state: the block hunts for
//   '$' and the registers return to margin 60, floor 50.
module hex_color_frame_parser_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [hcfp_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hcfp_pkg::CHAN_W-1:0]         red_value,
    output logic [hcfp_pkg::CHAN_W-1:0]         green_value,
    output logic [hcfp_pkg::CHAN_W-1:0]         blue_value,
    output logic                                is_red,
    output logic                                bad_digit,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hcfp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hcfp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hcfp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import hcfp_pkg::*;

    hcfp_cfg_t   cfg;
    hcfp_frame_t done;
    logic        done_ready;

    hcfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hcfp_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .done       (done),
        .done_ready (done_ready)
    );

    hcfp_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .done        (done),
        .done_ready  (done_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_value   (red_value),
        .green_value (green_value),
        .blue_value  (blue_value),
        .is_red      (is_red),
        .bad_digit   (bad_digit)
    );

endmodule

// ===== hdl/hcfp_checker.sv =====
`timescale 1ns / 1ps
// hcfp_checker: port-level checks of the hex color frame parser, bound to
// the top level. Depends on hcfp_pkg.
module hcfp_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [hcfp_pkg::CHAN_W-1:0]         red_value,
    input  logic [hcfp_pkg::CHAN_W-1:0]         green_value,
    input  logic [hcfp_pkg::CHAN_W-1:0]         blue_value,
    input  logic                                is_red,
    input  logic                                bad_digit,
    input  logic                                pready
);
    import hcfp_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // a bad digit always vetoes the red verdict
    a_bad_vetoes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_digit |-> !is_red)
        else $error("is_red set with bad digit");

    // red above the floor means red can never be zero
    a_red_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_red |-> red_value != '0)
        else $error("is_red with zero red channel");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_value)
        && $stable(green_value) && $stable(blue_value) && $stable(is_red)
        && $stable(bad_digit))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind hex_color_frame_parser_unit hcfp_checker u_hcfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red_value   (red_value),
    .green_value (green_value),
    .blue_value  (blue_value),
    .is_red      (is_red),
    .bad_digit   (bad_digit),
    .pready      (pready)
);
